/* rtl/satl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag lookup package
// Shared constants, configuration and row types, and the back-end state type.
// ----------------------------------------------------------------------------
package satl_pkg;

   localparam int MAX_WAYS        = 8;
   localparam int WAY_W           = 3;
   localparam int WAYS_W          = 4;
   localparam int MAX_SETS        = 256;
   localparam int SET_W           = 8;
   localparam int ADDR_WIDTH      = 32;
   localparam int TAG_W           = 32;
   localparam int RANK_W          = 3;
   localparam int LFSR_W          = 16;
   localparam int LFSR_CNT_W      = 4;
   localparam int SHIFT_W         = 5;
   localparam int CFG_W           = 4;
   localparam int CSR_INDEX_W     = 3;

   localparam logic [RANK_W-1:0]  RANK_MAX         = RANK_W'(MAX_WAYS - 1);
   localparam logic [LFSR_W-1:0]  LFSR_TAPS        = 16'hB400;
   localparam logic [LFSR_W-1:0]  LFSR_SEED        = 16'hACE1;
   localparam logic [CFG_W-1:0]   MAX_INDEX_BITS   = 4'd8;
   localparam logic [CFG_W-1:0]   MAX_OFFSET_BITS  = 4'd12;
   localparam logic [WAYS_W-1:0]  MAX_WAYS_CODE    = WAYS_W'(MAX_WAYS);

   // Replacement policy codes; the spare code behaves as FIFO.
   localparam logic [1:0] MODE_FIFO   = 2'd0;
   localparam logic [1:0] MODE_RANDOM = 2'd1;
   localparam logic [1:0] MODE_LRU    = 2'd2;

   // Request kinds.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WALLOC    = 3'd4;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WAYS_W-1:0] ways;        // clamped to 1..MAX_WAYS
      logic [CFG_W-1:0]  index_bits;  // clamped to 0..8
      logic [CFG_W-1:0]  offset_bits; // clamped to 0..12
      logic              walloc;
   } cfg_type;

   typedef struct packed {
      logic             alloc;
      logic [SET_W-1:0] set;
      logic [TAG_W-1:0] tag;
   } job_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0]              valid;
      logic [MAX_WAYS-1:0][TAG_W-1:0]   tags;
      logic [MAX_WAYS-1:0][RANK_W-1:0]  ranks;
      logic [WAY_W-1:0]                 fifo_ptr;
   } row_type;

   typedef struct packed {
      logic clearing;
      logic writing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_MOD,
      ST_WRITE
   } back_state_type;

endpackage

/* rtl/set_assoc_cache_tag_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup
// Reports hit or miss for each access and maintains valid bits, tags, FIFO
// pointers and LRU ranks with FIFO, random or LRU replacement.
// ----------------------------------------------------------------------------
// A request waits in a two-entry queue; the back end pops it and reads its set
// row (ST_IDLE), looks the row up (ST_EVAL), then writes it back and registers
// the response (ST_WRITE), waiting there while an earlier response is untaken.
// A random replacement adds a modulo step (ST_MOD). Requests are handled one at a
// time, by read-modify-write of one set row in the single-port tag memory.
// Reset: synchronous. After reset the back end clears all 256 set rows, one per
// cycle, and no request is accepted until the clearing pass is over.
module set_assoc_cache_tag_lookup import satl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // [31:0] address
   input  logic                    req_tuser,   // [0] req_type (0 read, 1 write)
   // Response channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,   // [0] hit, [8:1] set_index,
                                                // [40:9] tag_value, rest zero
   // Configuration write port
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   // Raw register contents; out-of-range values are clamped below.
   logic [1:0]        mode_ff;
   logic [CFG_W-1:0]  ways_ff;
   logic [CFG_W-1:0]  index_ff;
   logic [CFG_W-1:0]  offset_ff;
   logic              walloc_ff;

   cfg_type           cfg;
   job_type           front_job;
   job_type           head;
   logic              q_empty;
   logic              q_full;
   logic              q_push;
   logic              q_pop;
   back_status_type   stat;
   logic              rsp_hit;
   logic [SET_W-1:0]  rsp_set;
   logic [TAG_W-1:0]  rsp_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FIFO;
         ways_ff   <= 4'd1;
         index_ff  <= '0;
         offset_ff <= '0;
         walloc_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REPL_MODE: mode_ff   <= csr_wdata[1:0];
            CSR_WAYS:      ways_ff   <= csr_wdata;
            CSR_INDEX:     index_ff  <= csr_wdata;
            CSR_OFFSET:    offset_ff <= csr_wdata;
            CSR_WALLOC:    walloc_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the configuration once here so that both ends see legal values.
   always_comb begin
      cfg.mode        = mode_ff;
      cfg.walloc      = walloc_ff;
      if (ways_ff == '0) begin
         cfg.ways = WAYS_W'(1);
      end else if (ways_ff > MAX_WAYS_CODE) begin
         cfg.ways = MAX_WAYS_CODE;
      end else begin
         cfg.ways = ways_ff;
      end
      cfg.index_bits  = (index_ff > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_ff;
      cfg.offset_bits = (offset_ff > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_ff;
   end

   // Requests enter the queue whenever it has room and the clearing pass is over.
   assign req_tready = !stat.clearing && !q_full;
   assign q_push     = req_tvalid && req_tready;

   satl_front u_front (
      .cfg      (cfg),
      .req_kind (req_tuser),
      .req_addr (req_tdata),
      .job      (front_job)
   );

   satl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   satl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .status    (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_hit   (rsp_hit),
      .rsp_set   (rsp_set),
      .rsp_tag   (rsp_tag)
   );

   assign rsp_tdata = {7'd0, rsp_tag, rsp_set, rsp_hit};

   // A new response only appears out of the back end's write step.
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.writing))
      else $error("response appeared without a write step");

   // The queue is never pushed while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

   // The back end never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

   // No response may be pending when the clearing pass finishes.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      $fell(stat.clearing) |-> !rsp_tvalid)
      else $error("response during clearing pass");

endmodule

/* rtl/satl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag lookup front end
// Splits the address into set and tag and decides whether the request allocates.
// ----------------------------------------------------------------------------
module satl_front import satl_pkg::*; (
   input  cfg_type                 cfg,
   input  logic                    req_kind,
   input  logic [ADDR_WIDTH-1:0]   req_addr,
   output job_type                 job
);

   logic [ADDR_WIDTH-1:0] set_mask;
   logic [ADDR_WIDTH-1:0] set_full;
   logic [SHIFT_W-1:0]    tag_shift;

   always_comb begin
      set_mask  = (ADDR_WIDTH'(1) << cfg.index_bits) - ADDR_WIDTH'(1);
      set_full  = (req_addr >> cfg.offset_bits) & set_mask;
      tag_shift = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.index_bits);
      job.set   = set_full[SET_W-1:0];
      job.tag   = TAG_W'(req_addr >> tag_shift);
      job.alloc = (req_kind == REQ_READ) || cfg.walloc;
   end

endmodule

/* rtl/satl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag lookup job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module satl_queue import satl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      empty     = (count_ff == 2'd0);
      full      = (count_ff == 2'd2);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/satl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag lookup back end
// Read-modify-write of one set row: lookup, victim choice, update, result.
// ----------------------------------------------------------------------------
module satl_back import satl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  job_type           head,
   input  logic              empty,
   output logic              pop,
   output back_status_type   status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   output logic [SET_W-1:0]  rsp_set,
   output logic [TAG_W-1:0]  rsp_tag
);

   row_type row_mem [MAX_SETS];

   back_state_type      state_ff, state_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   job_type             job_ff, job_in;
   row_type             row_ff;
   logic                hit_ff, hit_in;
   logic [WAY_W-1:0]    hit_way_ff, hit_way_in;
   logic                free_ff, free_in;
   logic [WAY_W-1:0]    free_way_ff, free_way_in;
   logic [WAY_W-1:0]    lru_way_ff, lru_way_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [LFSR_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WAY_W-1:0]    rem_ff, rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [SET_W-1:0]    rsp_set_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;

   logic                rd_en;
   logic                wr_en;
   logic [SET_W-1:0]    wr_addr;
   row_type             wr_row;
   logic                fire;

   logic [MAX_WAYS-1:0] used;
   logic [LFSR_W-1:0]   lfsr_step;
   logic [WAYS_W-1:0]   rem_dbl;
   logic [WAY_W-1:0]    ptr_way;
   logic [WAY_W-1:0]    touched;
   logic [RANK_W-1:0]   old_rank;
   logic                is_fill;
   logic                do_touch;
   row_type             new_row;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         used[w] = (WAYS_W'(w) < cfg.ways);
      end
      lfsr_step = lfsr_ff >> 1;
      if (lfsr_ff[0]) begin
         lfsr_step = lfsr_step ^ LFSR_TAPS;
      end
      rem_dbl = {rem_ff, lfsr_ff[LFSR_W - 1 - int'(cnt_ff)]};
   end

   // Lookup on the registered row.
   always_comb begin
      hit_in      = 1'b0;
      hit_way_in  = '0;
      free_in     = 1'b0;
      free_way_in = '0;
      lru_way_in  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (used[w] && row_ff.valid[w] && (row_ff.tags[w] == job_ff.tag)) begin
            hit_in     = 1'b1;
            hit_way_in = WAY_W'(w);
         end
         if (used[w] && !row_ff.valid[w]) begin
            free_in     = 1'b1;
            free_way_in = WAY_W'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (used[w] && (row_ff.ranks[w] > row_ff.ranks[lru_way_in])) begin
            lru_way_in = WAY_W'(w);
         end
      end
   end

   // Row update for the write step.
   always_comb begin
      new_row  = row_ff;
      ptr_way  = (WAYS_W'(row_ff.fifo_ptr) < cfg.ways) ? row_ff.fifo_ptr : '0;
      is_fill  = 1'b0;
      do_touch = (cfg.mode == MODE_LRU);
      if (hit_ff) begin
         touched = hit_way_ff;
      end else if (free_ff) begin
         touched = free_way_ff;
         is_fill = 1'b1;
         new_row.valid[free_way_ff] = 1'b1;
         new_row.tags[free_way_ff]  = job_ff.tag;
      end else if (cfg.mode == MODE_RANDOM) begin
         touched = rem_ff;
         new_row.tags[rem_ff] = job_ff.tag;
      end else if (cfg.mode == MODE_LRU) begin
         touched = lru_way_ff;
         new_row.tags[lru_way_ff] = job_ff.tag;
      end else begin
         touched = ptr_way;
         do_touch = 1'b0;
         new_row.tags[ptr_way] = job_ff.tag;
         new_row.fifo_ptr = (WAYS_W'(ptr_way) + WAYS_W'(1) == cfg.ways) ?
                            '0 : ptr_way + WAY_W'(1);
      end
      old_rank = row_ff.ranks[touched];
      if (do_touch) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (used[w] && row_ff.valid[w] && (WAY_W'(w) != touched) &&
                (is_fill || (row_ff.ranks[w] < old_rank)) &&
                (row_ff.ranks[w] != RANK_MAX)) begin
               new_row.ranks[w] = row_ff.ranks[w] + RANK_W'(1);
            end
         end
         new_row.ranks[touched] = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      lfsr_in      = lfsr_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = job_ff.set;
      wr_row       = new_row;
      fire         = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_row  = '0;
            clr_in  = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               job_in   = head;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (job_ff.alloc && !hit_in && !free_in && (cfg.mode == MODE_RANDOM)) begin
               lfsr_in  = lfsr_step;
               cnt_in   = '0;
               rem_in   = '0;
               state_in = ST_MOD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MOD: begin
            // One bit per cycle: rem = (2*rem + bit) mod ways.
            rem_in = (rem_dbl >= cfg.ways) ? WAY_W'(rem_dbl - cfg.ways) : WAY_W'(rem_dbl);
            cnt_in = cnt_ff + LFSR_CNT_W'(1);
            if (cnt_ff == LFSR_CNT_W'(LFSR_W - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fire         = 1'b1;
               wr_en        = job_ff.alloc;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      if (state_ff == ST_EVAL) begin
         hit_ff      <= hit_in;
         hit_way_ff  <= hit_way_in;
         free_ff     <= free_in;
         free_way_ff <= free_way_in;
         lru_way_ff  <= lru_way_in;
      end
      if (fire) begin
         rsp_hit_ff <= hit_ff;
         rsp_set_ff <= job_ff.set;
         rsp_tag_ff <= job_ff.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_ff <= row_mem[head.set];
      end
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.writing  = (state_ff == ST_WRITE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_set         = rsp_set_ff;
   assign rsp_tag         = rsp_tag_ff;

endmodule

/* test/set_assoc_cache_tag_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag lookup testbench
// Sends read and write requests under several cache geometries and replacement
// policies. A built-in cache predictor gives the expected hit, set and tag for
// every request, and the responses are compared in order.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_tb;
   import satl_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // [31:0] address
   logic                   req_tuser;   // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [47:0]            rsp_tdata;   // [0] hit, [8:1] set_index, [40:9] tag_value
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   set_assoc_cache_tag_lookup dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic             hit;
      logic [SET_W-1:0] set;
      logic [TAG_W-1:0] tag;
   } lookup_type;

   // Directed row: the expected lookup is typed in only when known_result is set.
   typedef struct {
      logic       kind;
      logic [31:0] addr;
      bit         known_result;
      lookup_type result;
   } probe_type;

   // Shadow copy of the cache state and configuration.
   logic [1:0]  mdl_mode;
   logic [3:0]  mdl_ways;
   logic [3:0]  mdl_index_bits;
   logic [3:0]  mdl_offset_bits;
   logic        mdl_walloc;
   logic        mdl_valid [MAX_SETS][MAX_WAYS];
   logic [31:0] mdl_tag [MAX_SETS][MAX_WAYS];
   logic [2:0]  mdl_ptr [MAX_SETS];
   logic [2:0]  mdl_rank [MAX_SETS][MAX_WAYS];
   logic [15:0] mdl_lfsr;

   lookup_type expected_lookups[$];
   int         error_count = 0;
   int         response_count = 0;
   int         hit_count = 0;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;
   bit         hold_off = 0;

   // Age every valid way younger than old_rank, then make way the youngest.
   function automatic void promote_way(int set, int way, int ways, int old_rank);
      for (int w = 0; w < ways; w++) begin
         if (w != way && mdl_valid[set][w] && mdl_rank[set][w] < old_rank
             && mdl_rank[set][w] < MAX_WAYS - 1)
            mdl_rank[set][w] = mdl_rank[set][w] + 1;
      end
      mdl_rank[set][way] = 0;
   endfunction

   function automatic lookup_type predict_lookup(logic kind, logic [31:0] addr);
      int ways, ib, ob, set, hit_way, victim;
      logic [1:0] mode;
      logic [31:0] tag;
      bit hit, found;
      lookup_type r;
      ways = (mdl_ways == 0) ? 1 : (mdl_ways > MAX_WAYS ? MAX_WAYS : mdl_ways);
      ib = mdl_index_bits > 8 ? 8 : mdl_index_bits;
      ob = mdl_offset_bits > 12 ? 12 : mdl_offset_bits;
      mode = (mdl_mode == 2'd3) ? MODE_FIFO : mdl_mode;
      set = int'((addr >> ob) & ((32'd1 << ib) - 1));
      tag = 32'(64'(addr) >> (ob + ib));
      hit = 0;
      hit_way = 0;
      found = 0;
      victim = 0;
      for (int w = 0; w < ways; w++) begin
         if (!hit && mdl_valid[set][w] && mdl_tag[set][w] == tag) begin
            hit = 1;
            hit_way = w;
         end
      end
      if (kind == REQ_READ || mdl_walloc) begin
         if (hit) begin
            if (mode == MODE_LRU) promote_way(set, hit_way, ways, mdl_rank[set][hit_way]);
         end else begin
            for (int w = ways - 1; w >= 0; w--) begin
               if (!mdl_valid[set][w]) begin
                  victim = w;
                  found = 1;
               end
            end
            if (found) begin
               mdl_valid[set][victim] = 1;
               mdl_tag[set][victim] = tag;
               if (mode == MODE_LRU) promote_way(set, victim, ways, 32'hFFFF_FFFF >> 1);
            end else if (mode == MODE_FIFO) begin
               victim = mdl_ptr[set] < ways ? mdl_ptr[set] : 0;
               mdl_tag[set][victim] = tag;
               mdl_ptr[set] = 3'((victim + 1) % ways);
            end else if (mode == MODE_RANDOM) begin
               mdl_lfsr = mdl_lfsr[0] ? ((mdl_lfsr >> 1) ^ LFSR_TAPS) : (mdl_lfsr >> 1);
               victim = mdl_lfsr % ways;
               mdl_tag[set][victim] = tag;
            end else begin
               for (int w = 1; w < ways; w++)
                  if (mdl_rank[set][w] > mdl_rank[set][victim]) victim = w;
               mdl_tag[set][victim] = tag;
               promote_way(set, victim, ways, mdl_rank[set][victim]);
            end
         end
      end
      r.hit = hit;
      r.set = SET_W'(set);
      r.tag = tag;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Offer one request and hold it until accepted. The request stays offered
   // after acceptance until the next request or a drain decides otherwise.
   task automatic send_request(logic kind, logic [31:0] addr);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= addr;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      expected_lookups.push_back(predict_lookup(kind, addr));
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 0;
      while (expected_lookups.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      case (idx)
         CSR_REPL_MODE: mdl_mode = value[1:0];
         CSR_WAYS:      mdl_ways = value;
         CSR_INDEX:     mdl_index_bits = value;
         CSR_OFFSET:    mdl_offset_bits = value;
         CSR_WALLOC:    mdl_walloc = value[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [1:0] mode, logic [3:0] ways, logic [3:0] ib,
                               logic [3:0] ob, logic walloc);
      drain_responses();
      write_csr(CSR_REPL_MODE, {2'b00, mode});
      write_csr(CSR_WAYS, ways);
      write_csr(CSR_INDEX, ib);
      write_csr(CSR_OFFSET, ob);
      write_csr(CSR_WALLOC, {3'b000, walloc});
      csr_we <= 0;
   endtask

   // Random address: mostly a small pool of tags and sets so that lines are
   // reused and sets fill up; sometimes anything at all.
   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      a = $urandom();
      if ($urandom_range(9) < 8) begin
         a = (32'($urandom_range(7)) << 16) ^ (a & 32'h0000_0FFF);
         a = a | (32'($urandom_range(7)) << ((mdl_offset_bits > 12 ? 12 : mdl_offset_bits)
                  + (mdl_index_bits > 8 ? 8 : mdl_index_bits)));
         a[31] = $urandom_range(1);
      end
      return a;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_request(logic'($urandom_range(1)), pick_address());
   endtask

   // Response checker: every accepted response is matched with the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         lookup_type want;
         if (expected_lookups.size() == 0) begin
            $display("%0t: response with nothing expected: %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_lookups.pop_front();
            response_count++;
            if (rsp_tdata[0]) hit_count++;
            if (rsp_tdata[0] !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[8:1] !== want.set) begin
               $display("%0t: set expected %0d actual %0d", $time, want.set, rsp_tdata[8:1]);
               error_count++;
            end
            if (rsp_tdata[40:9] !== want.tag) begin
               $display("%0t: tag expected %h actual %h", $time, want.tag, rsp_tdata[40:9]);
               error_count++;
            end
         end
      end
   end

   // Receiver back-pressure, with an occasional long hold-off on request.
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (60) @(negedge clock);
            hold_off = 0;
         end
         rsp_tready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
      end
   end

   // Directed table: reset state first, so the first rows are known, alternating
   // misses and hits in the single set of a one-way cache.
   probe_type probes[] = '{
      '{REQ_READ,  32'h0000_0000, 1, '{1'b0, 8'd0, 32'h0000_0000}},
      '{REQ_READ,  32'h0000_0000, 1, '{1'b1, 8'd0, 32'h0000_0000}},
      '{REQ_WRITE, 32'hFFFF_FFFF, 1, '{1'b0, 8'd0, 32'hFFFF_FFFF}},
      '{REQ_READ,  32'hFFFF_FFFF, 1, '{1'b1, 8'd0, 32'hFFFF_FFFF}},
      '{REQ_READ,  32'h0000_0000, 1, '{1'b0, 8'd0, 32'h0000_0000}},
      '{REQ_WRITE, 32'h5555_AAAA, 0, '0},
      '{REQ_READ,  32'hAAAA_5555, 0, '0},
      '{REQ_WRITE, 32'hAAAA_5555, 0, '0}
   };

   initial begin
      lookup_type got;
      req_tvalid = 0;
      req_tdata  = 0;
      req_tuser  = 0;
      csr_we     = 0;
      csr_index  = 0;
      csr_wdata  = 0;
      reset      = 1;
      mdl_mode = MODE_FIFO;
      mdl_ways = 1;
      mdl_index_bits = 0;
      mdl_offset_bits = 0;
      mdl_walloc = 1;
      mdl_lfsr = LFSR_SEED;
      for (int s = 0; s < MAX_SETS; s++) begin
         mdl_ptr[s] = 0;
         for (int w = 0; w < MAX_WAYS; w++) begin
            mdl_valid[s][w] = 0;
            mdl_tag[s][w] = 0;
            mdl_rank[s][w] = 0;
         end
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed rows with the reset configuration; typed results are checked
      // against the predictor so a slip in either shows up.
      receiver_idle_pct = 0;
      foreach (probes[i]) begin
         send_request(probes[i].kind, probes[i].addr);
         got = expected_lookups[expected_lookups.size() - 1];
         if (probes[i].known_result && got !== probes[i].result) begin
            $display("%0t: row %0d expected %h actual %h", $time, i,
                     probes[i].result, got);
            error_count++;
         end
      end

      // Extremes of the geometry: out-of-range ways, wide index and offset,
      // the spare mode code and lookup-only writes.
      set_geometry(2'd3, 4'd0, 4'd15, 4'd15, 1'b0);
      send_request(REQ_WRITE, 32'hFFFF_FFFF);
      send_request(REQ_READ,  32'hFFFF_FFFF);
      send_request(REQ_READ,  32'hFFFF_FFFF);
      set_geometry(MODE_LRU, 4'd15, 4'd8, 4'd12, 1'b1);
      for (int k = 0; k < 10; k++)
         send_request(logic'(k & 1), 32'h0010_0000 * k);
      send_request(REQ_READ, 32'h0);

      // Random phases across policies and geometries.
      sender_idle_pct = 28;
      receiver_idle_pct = 59;
      set_geometry(MODE_FIFO, 4'd4, 4'd2, 4'd3, 1'b1);
      random_phase(200);
      set_geometry(MODE_RANDOM, 4'd8, 4'd1, 4'd0, 1'b1);
      random_phase(200);
      sender_idle_pct = 59;
      receiver_idle_pct = 28;
      set_geometry(MODE_LRU, 4'd8, 4'd0, 4'd5, 1'b1);
      random_phase(200);
      set_geometry(MODE_LRU, 4'd3, 4'd3, 4'd12, 1'b0);
      random_phase(150);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_geometry(MODE_RANDOM, 4'd3, 4'd8, 4'd2, 1'b1);
      hold_off = 1;
      random_phase(150);
      set_geometry(MODE_FIFO, 4'd1, 4'd0, 4'd0, 1'b0);
      random_phase(100);
      set_geometry(MODE_FIFO, 4'd7, 4'd1, 4'd1, 1'b1);
      random_phase(200);
      drain_responses();

      $display("Checked %0d lookups (%0d hits) over FIFO, random and LRU policies,",
               response_count, hit_count);
      $display("ways 1 to 8, index 0 to 8 bits and offset 0 to 12 bits.");
      if (error_count == 0 && expected_lookups.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
rtl/satl_pkg.sv
rtl/satl_front.sv
rtl/satl_queue.sv
rtl/satl_back.sv
rtl/set_assoc_cache_tag_lookup.sv
test/set_assoc_cache_tag_lookup_tb.sv
